FILE: rtl/idwe_pkg.sv
// Package: shared constants and types for the inverse distance warp evaluator.
package idwe_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int CW         = 20;
    localparam int PW         = 16;
    localparam logic [CW-1:0] FIELD_MAX = 20'sh7FFFF;
    localparam logic [CW-1:0] FIELD_MIN = 20'sh80000;
    localparam logic REG_ACTIVE = 1'b0;
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    typedef struct packed {
        logic        go;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;
endpackage

FILE: rtl/idwe_divider.sv
// Shared restoring divider, one quotient bit per cycle, 64-bit operands.
module idwe_divider import idwe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic [63:0] r_q, r_rem, r_den;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb begin
        shifted = {r_rem, r_q[63]};
        trial   = shifted - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!trial[64]) begin
                    r_rem <= trial[63:0];
                    r_q   <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= shifted[63:0];
                    r_q   <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/idwe_isqrt.sv
// Bit-serial integer square root of a 50-bit value, one result bit per cycle.
module idwe_isqrt import idwe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [49:0] i_val,
    output logic        o_done,
    output logic [24:0] o_root
);
    logic [49:0] r_v;
    logic [26:0] r_rem;
    logic [24:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [26:0] nrem, trial;

    always_comb begin
        nrem  = {r_rem[24:0], r_v[49:48]};
        trial = nrem - {r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_v <= {r_v[47:0], 2'b00};
                if (!trial[26]) begin
                    r_rem  <= trial;
                    r_root <= {r_root[23:0], 1'b1};
                end else begin
                    r_rem  <= nrem;
                    r_root <= {r_root[23:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd24) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

FILE: rtl/inverse_distance_warp_evaluator.sv
// Top level: control point table, sequencer and accumulators of the evaluator.
// Usage: a load (i_command=0) writes one control point entry in the cycle it is accepted;
// busy stays low, so loads can follow back to back. An evaluate (i_command=1) visits each
// of the first active_points entries in turn. Per entry: table read, distance, root start,
// square root wait, 2^40/s reciprocal on the shared 64-step divider, then a multiply step
// and an accumulate step. Then a last table check, two divider passes for the two rounded
// means and an output state; o_valid rises in the same cycle that busy falls. A pixel that
// lands exactly on an active point stops the walk there and returns that point's
// coefficients with o_exact_hit high; an active count of zero goes straight to the output.
// busy is high for the whole item; the result is shown for one cycle with o_valid and
// cannot be stalled, so the receiver must take every word as it appears.
module inverse_distance_warp_evaluator import idwe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_command,
    input  logic [5:0]           i_point_index,
    input  logic [15:0]          i_point_x,
    input  logic [15:0]          i_point_y,
    input  logic signed [19:0]   i_weight_u,
    input  logic signed [19:0]   i_weight_v,
    input  logic [11:0]          i_pixel_x,
    input  logic [11:0]          i_pixel_y,
    output logic                 o_valid,
    output logic signed [19:0]   o_map_u,
    output logic signed [19:0]   o_map_v,
    output logic                 o_exact_hit
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_DIST = 4'd2, S_SQ = 4'd3,
                           S_SQW = 4'd4, S_RCP = 4'd5, S_MAC = 4'd6, S_MAC2 = 4'd7,
                           S_DU = 4'd8, S_DUW = 4'd9, S_DV = 4'd10, S_DVW = 4'd11,
                           S_OUT = 4'd12;

    // table memories, one read port registered
    logic [PW-1:0] m_x [MAX_POINTS];
    logic [PW-1:0] m_y [MAX_POINTS];
    logic [CW-1:0] m_u [MAX_POINTS];
    logic [CW-1:0] m_v [MAX_POINTS];

    logic [3:0]       r_st;
    logic [CNT_W-1:0] r_act, r_i, r_n;
    logic [PW-1:0]    r_px, r_py, r_cx, r_cy;
    logic signed [CW-1:0] r_cu, r_cv;
    logic [33:0]      r_d;
    logic [32:0]      r_w;
    logic [63:0]      r_sw;
    logic signed [63:0] r_su, r_sv;
    logic signed [63:0] r_pu, r_pv;
    logic             r_neg;
    logic             r_valid, r_hit;
    logic signed [CW-1:0] r_mu, r_mv;
    t_div_req         div_req;
    logic             div_done, sq_go, sq_done;
    logic [63:0]      div_q;
    logic [24:0]      sq_root;
    logic [16:0]      dx, dy;
    logic [63:0]      mag, q;
    logic signed [CW-1:0] res;
    // weight (33 bit, positive) times coefficient (20 bit, signed)
    logic signed [53:0] prod_u, prod_v;

    assign pready = 1'b1;
    assign prdata = (paddr == {1'b0, REG_ACTIVE}) ? {25'd0, r_act} : 32'd0;
    assign busy   = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 7'd1;
        end else if (psel && penable && pwrite && paddr[1:0] == {1'b0, REG_ACTIVE}) begin
            r_act <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_command == CMD_LOAD) begin
            m_x[i_point_index] <= i_point_x;
            m_y[i_point_index] <= i_point_y;
            m_u[i_point_index] <= i_weight_u;
            m_v[i_point_index] <= i_weight_v;
        end
        r_cx <= m_x[r_i[IDX_W-1:0]];
        r_cy <= m_y[r_i[IDX_W-1:0]];
        r_cu <= m_u[r_i[IDX_W-1:0]];
        r_cv <= m_v[r_i[IDX_W-1:0]];
    end

    always_comb begin
        dx = (r_px >= r_cx) ? {1'b0, r_px - r_cx} : {1'b0, r_cx - r_px};
        dy = (r_py >= r_cy) ? {1'b0, r_py - r_cy} : {1'b0, r_cy - r_py};
        prod_u = $signed({1'b0, r_w}) * r_cu;
        prod_v = $signed({1'b0, r_w}) * r_cv;
        div_req = '0;
        sq_go   = (r_st == S_SQ);
        if (r_st == S_SQW && sq_done) begin
            div_req.go  = 1'b1;
            div_req.num = 64'd1 << 40;
            div_req.den = {39'd0, sq_root};
        end else if (r_st == S_DU || r_st == S_DV) begin
            div_req.go  = 1'b1;
            div_req.num = ((r_st == S_DU) ? (r_su[63] ? -r_su : r_su)
                                          : (r_sv[63] ? -r_sv : r_sv)) + (r_sw >> 1);
            div_req.den = r_sw;
        end
        mag = div_q;
        q   = (mag > 64'd1048576) ? 64'd1048576 : mag;
        if (r_neg) res = (q >= 64'd524288) ? FIELD_MIN : -q[CW-1:0];
        else       res = (q >= 64'd524287) ? FIELD_MAX : q[CW-1:0];
    end

    idwe_isqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(sq_go),
        .i_val({r_d, 16'd0}), .o_done(sq_done), .o_root(sq_root)
    );
    idwe_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_valid <= 1'b0;
            r_i     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    r_i <= '0;
                    if (start && i_command == CMD_EVAL) begin
                        r_px <= {i_pixel_x, 4'd0};
                        r_py <= {i_pixel_y, 4'd0};
                        r_n  <= (r_act > 7'(MAX_POINTS)) ? 7'(MAX_POINTS) : r_act;
                        r_sw <= '0; r_su <= '0; r_sv <= '0;
                        r_hit <= 1'b0;
                        r_mu <= '0; r_mv <= '0;
                        r_st <= S_RD;
                    end
                end
                S_RD: r_st <= (r_i == r_n) ? ((r_n == '0) ? S_OUT : S_DU) : S_DIST;
                S_DIST: begin
                    r_d  <= 34'({17'd0, dx} * {17'd0, dx}) + 34'({17'd0, dy} * {17'd0, dy});
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    if (r_d == '0) begin
                        r_hit <= 1'b1;
                        r_mu  <= r_cu;
                        r_mv  <= r_cv;
                        r_st  <= S_OUT;
                    end else r_st <= S_SQW;
                end
                S_SQW: if (sq_done) r_st <= S_RCP;
                S_RCP: if (div_done) begin
                    r_w  <= div_q[32:0];
                    r_st <= S_MAC;
                end
                S_MAC: begin
                    r_pu <= 64'(prod_u);
                    r_pv <= 64'(prod_v);
                    r_st <= S_MAC2;
                end
                S_MAC2: begin
                    r_sw <= r_sw + {31'd0, r_w};
                    r_su <= r_su + r_pu;
                    r_sv <= r_sv + r_pv;
                    r_i  <= r_i + 7'd1;
                    r_st <= S_RD;
                end
                S_DU: begin r_neg <= r_su[63]; r_st <= S_DUW; end
                S_DUW: if (div_done) begin r_mu <= res; r_st <= S_DV; end
                S_DV: begin r_neg <= r_sv[63]; r_st <= S_DVW; end
                S_DVW: if (div_done) begin r_mv <= res; r_st <= S_OUT; end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_valid;
    assign o_map_u     = r_mu;
    assign o_map_v     = r_mv;
    assign o_exact_hit = r_hit;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_st == S_IDLE) else $error("result outside idle");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_i <= r_n) else $error("point counter overran");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |=> r_valid) else $error("missing result strobe");
endmodule
